// ===== sv/bsm_pkg.sv =====
// Shared definitions for the bounded set with minimum block.
// Holds operation and status codes, defaults and the scan control struct.
// Used by every module of the block and by its checker.
package bsm_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned OCNT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [VAL_W-1:0]   EMPTY_MIN   = 32'hFFFF_FFFF;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [STAT_W-1:0] ST_QUERY     = 3'd5;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

// ===== sv/bsm_mem.sv =====
// Entry store: one write port and one read port with registered read data.
// Depends on bsm_pkg for the value width.
module bsm_mem
  import bsm_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bsm_scan.sv =====
// Scan accumulator: looks for the request value among the entries read
// one per cycle and keeps the smallest entry that differs from it.
// Depends on bsm_pkg for the control struct and the value width.
module bsm_scan
  import bsm_pkg::*;
#(
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  input  logic [VAL_W-1:0] key,
  input  logic [VAL_W-1:0] rdata,
  input  logic [IDX_W-1:0] ridx,
  output logic             found,
  output logic [IDX_W-1:0] slot,
  output logic             have_min,
  output logic [VAL_W-1:0] min_val
);

  // Entries are distinct, so skipping the matching entry leaves exactly the
  // minimum of the set with that value taken out.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found    <= 1'b0;
      have_min <= 1'b0;
    end else if (ctl.sample) begin
      if (rdata == key) begin
        found <= 1'b1;
      end else if (!have_min || ($signed(rdata) < $signed(min_val))) begin
        have_min <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      if (rdata == key) begin
        slot <= ridx;
      end else if (!have_min || ($signed(rdata) < $signed(min_val))) begin
        min_val <= rdata;
      end
    end
  end

endmodule

// ===== sv/bounded_set_with_minimum.sv =====
// Bounded set of distinct signed 32-bit values with a minimum. Each request
// (s_tuser = operation, s_tdata = value) inserts, removes or only queries and
// yields one result with status, count, minimum (-1 when empty) and an empty
// flag. The block handles one request at a time: it reads every held entry
// from the entry memory at one entry per cycle (none when the set is empty),
// and a remove that finds its value then reads the last entry and moves it
// into the freed slot. A finished result waits in the output register while
// the next request is taken. The limit register is written through
// cfg_we/cfg_wdata; the user must write it only while no request is in
// flight, as the block itself does not enforce this. A limit above CAPACITY
// acts as CAPACITY.
module bounded_set_with_minimum
  import bsm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,  // max_entries
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [VAL_W-1:0]    s_tdata,    // [31:0] value
  input  logic [MODE_W-1:0]   s_tuser,    // [1:0] mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,    // [6:0] entry_count, [38:7] minimum, [39] is_empty
  output logic [STAT_W-1:0]   m_tuser     // [2:0] status
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_SWAIT   = 3'd2;
  localparam logic [2:0] S_DECIDE  = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]         state, state_next;
  logic [LIMIT_W-1:0] max_entries;
  logic [CNT_W-1:0]   count, count_next;
  logic [MODE_W-1:0]  op_mode;
  logic [VAL_W-1:0]   key;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   samp_idx;
  logic               samp_vld;
  logic [STAT_W-1:0]  res_status, res_status_next;
  logic [VAL_W-1:0]   res_min, res_min_next;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [VAL_W-1:0]   mem_wdata, mem_rdata;

  scan_ctl_t          sctl;
  logic               found, have_min;
  logic [IDX_W-1:0]   slot;
  logic [VAL_W-1:0]   min_other;

  logic               accept, scan_last, full_now, incl_v, out_load;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CMP_W-1:0]   cnt_x, max_x, cap_x, lim_x;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);
  assign cnt_dec   = count - CNT_W'(1);
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  assign cnt_x    = CMP_W'(count);
  assign max_x    = CMP_W'(max_entries);
  assign cap_x    = CMP_W'(CAPACITY);
  assign lim_x    = (max_x > cap_x) ? cap_x : max_x;
  assign full_now = (cnt_x >= lim_x);

  assign sctl.clear  = accept;
  assign sctl.sample = samp_vld;

  bsm_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsm_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sctl),
    .key      (key),
    .rdata    (mem_rdata),
    .ridx     (samp_idx),
    .found    (found),
    .slot     (slot),
    .have_min (have_min),
    .min_val  (min_other)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = count[IDX_W-1:0];
    mem_wdata       = key;
    mem_re          = 1'b0;
    mem_raddr       = scan_idx;
    incl_v          = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (count == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
        if (scan_last) begin
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_DONE;
        case (op_mode)
          MODE_INSERT: begin
            if (full_now) begin
              res_status_next = ST_FULL;
              incl_v          = found;
            end else if (found) begin
              res_status_next = ST_DUPLICATE;
              incl_v          = 1'b1;
            end else begin
              res_status_next = ST_INSERTED;
              incl_v          = 1'b1;
              mem_we          = 1'b1;
              count_next      = count + CNT_W'(1);
            end
          end
          MODE_REMOVE: begin
            if (found) begin
              // Fetch the last entry; it fills the freed slot next cycle.
              res_status_next = ST_REMOVED;
              count_next      = cnt_dec;
              mem_re          = 1'b1;
              mem_raddr       = cnt_dec[IDX_W-1:0];
              state_next      = S_MOVE_WR;
            end else begin
              res_status_next = ST_NOTFOUND;
            end
          end
          default: begin
            res_status_next = ST_QUERY;
            incl_v          = found;
          end
        endcase
      end
      S_MOVE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = slot;
        mem_wdata  = mem_rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (have_min) begin
      res_min_next = (incl_v && ($signed(key) < $signed(min_other))) ? key : min_other;
    end else begin
      res_min_next = incl_v ? key : EMPTY_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      max_entries <= LIMIT_RESET;
      samp_vld    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      samp_vld <= (state == S_SCAN);
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    samp_idx <= scan_idx;
    if (accept) begin
      op_mode  <= s_tuser;
      key      <= s_tdata;
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == S_DECIDE) begin
      res_status <= res_status_next;
      res_min    <= res_min_next;
    end
    if (out_load) begin
      m_tuser       <= res_status;
      m_tdata[6:0]  <= OCNT_W'(count);
      m_tdata[38:7] <= res_min;
      m_tdata[39]   <= (count == '0);
    end
  end

endmodule

// ===== sv/bsm_checker.sv =====
// Port-level checker for the bounded set with minimum block, bound to its top.
// Depends on bsm_pkg for the status codes.
module bsm_checker
  import bsm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [39:0]       m_tdata,
  input logic [STAT_W-1:0] m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |-> (m_tdata[38:7] == EMPTY_MIN) && (m_tdata[6:0] == '0))
    else $error("empty set reports a minimum or a count");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_INSERTED) || (m_tuser == ST_DUPLICATE)) |-> !m_tdata[39])
    else $error("set reported empty after holding the request value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_QUERY))
    else $error("status code out of range");

endmodule

bind bounded_set_with_minimum bsm_checker u_bsm_checker (.*);

// ===== dv/bounded_set_with_minimum_tb.sv =====
// Self-checking testbench for the bounded set with minimum block.
// Holds a scoreboard class that tracks the set and its limit, plus the stream drivers.
// Depends on bsm_pkg and bounded_set_with_minimum from the RTL.
`timescale 1ns / 100ps

module bounded_set_with_minimum_tb;
  import bsm_pkg::*;

  // The fourth operation code has no name in the package; the block treats it as a query.
  localparam logic [MODE_W-1:0] MODE_QUERY_ALT = 2'd3;
  localparam int unsigned N_PHASES = 9;
  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] count;
    logic [VAL_W-1:0]  minimum;
    logic              empty;
  } outcome_t;

  typedef struct {
    logic [LIMIT_W-1:0] limit;
    int unsigned        insert_pct;
    int unsigned        remove_pct;
    int unsigned        items;
    int unsigned        spread;
  } plan_t;

  class set_scoreboard;
    logic [VAL_W-1:0] held[CAPACITY_DEF];
    int unsigned      held_count = 0;
    int unsigned      limit = LIMIT_RESET;
    outcome_t         awaited[$];
    int unsigned      failures = 0;
    int unsigned      requests = 0;
    int unsigned      results = 0;
    int unsigned      peak = 0;
    int unsigned      status_hits[8];

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = (v > CAPACITY_DEF) ? CAPACITY_DEF : v;
    endfunction

    function int slot_of(logic [VAL_W-1:0] v);
      for (int i = 0; i < held_count; i++)
        if (held[i] == v) return i;
      return -1;
    endfunction

    function logic [VAL_W-1:0] some_held();
      return held[$urandom_range(0, held_count - 1)];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value);
      outcome_t         o;
      int               slot;
      logic [VAL_W-1:0] low;
      slot = slot_of(value);
      if (mode == MODE_INSERT) begin
        // A full set wins over a duplicate.
        if (held_count >= limit) begin
          o.status = ST_FULL;
        end else if (slot >= 0) begin
          o.status = ST_DUPLICATE;
        end else begin
          held[held_count] = value;
          held_count++;
          o.status = ST_INSERTED;
        end
      end else if (mode == MODE_REMOVE) begin
        if (slot >= 0) begin
          held[slot] = held[held_count - 1];
          held_count--;
          o.status = ST_REMOVED;
        end else begin
          o.status = ST_NOTFOUND;
        end
      end else begin
        o.status = ST_QUERY;
      end
      low = EMPTY_MIN;
      for (int i = 0; i < held_count; i++)
        if (i == 0 || $signed(held[i]) < $signed(low)) low = held[i];
      o.count = OCNT_W'(held_count);
      o.minimum = low;
      o.empty = (held_count == 0);
      awaited.push_back(o);
      requests++;
      status_hits[o.status]++;
      if (held_count > peak) peak = held_count;
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [39:0] data);
      outcome_t want, got;
      got.status = status;
      got.count = data[6:0];
      got.minimum = data[38:7];
      got.empty = data[39];
      results++;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result %0d: status %0d count %0d min %0d empty %0b",
                       results, got.status, got.count, $signed(got.minimum), got.empty));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.minimum !== want.minimum || got.empty !== want.empty)
        flag($sformatf({"result %0d: expected status %0d count %0d min %0d empty %0b, ",
                        "got status %0d count %0d min %0d empty %0b"}, results,
                       want.status, want.count, $signed(want.minimum), want.empty,
                       got.status, got.count, $signed(got.minimum), got.empty));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [VAL_W-1:0]    s_tdata = '0;
  logic [MODE_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [39:0]         m_tdata;
  logic [STAT_W-1:0]   m_tuser;

  set_scoreboard sb;
  bit            src_calm = 1'b0;
  bit            sink_calm = 1'b0;
  int unsigned   settings = 0;
  int unsigned   idle_cycles = 0;

  bounded_set_with_minimum dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  // Mostly values from a narrow window so that duplicates and remove hits are common.
  function automatic logic [VAL_W-1:0] pick_value(int unsigned spread);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 25) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h8000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic plan_t phase_plan(int unsigned idx);
    plan_t p;
    case (idx)
      0: p = '{7'd127, 80, 10, 150, 50};
      1: p = '{7'd64,  40, 45, 150, 50};
      2: p = '{7'd3,   30, 50, 150, 20};
      3: p = '{7'd0,   30, 40, 80,  10};
      4: p = '{7'd65,  60, 25, 150, 40};
      5: p = '{7'd1,   50, 35, 120, 4};
      6: p = '{7'd17,  50, 35, 150, 12};
      7: p = '{7'd64,  45, 40, 200, 60};
      default: p = '{7'd100, 70, 15, 200, 45};
    endcase
    return p;
  endfunction

  // Called at a falling edge with tvalid low; returns at a falling edge with tvalid low.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(src_calm);
    repeat (gap) @(negedge clk);
    s_tuser = mode;
    s_tdata = value;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(mode, value);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    wait_drained();
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_limit(v);
    settings++;
  endtask

  task automatic random_request(plan_t p);
    int unsigned       r;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  value;
    r = $urandom_range(0, 99);
    if (r < p.insert_pct) mode = MODE_INSERT;
    else if (r < p.insert_pct + p.remove_pct) mode = MODE_REMOVE;
    else if (r % 4 == 0) mode = MODE_QUERY_ALT;
    else mode = MODE_QUERY;
    if (mode == MODE_REMOVE && sb.held_count > 0 && $urandom_range(0, 99) < 60)
      value = sb.some_held();
    else
      value = pick_value(p.spread);
    send_request(mode, value);
  endtask

  task automatic run_directed();
    // Empty set: both query codes and a remove that cannot hit.
    send_request(MODE_QUERY, 32'h1234_5678);
    send_request(MODE_QUERY_ALT, 32'hFFFF_FFFF);
    send_request(MODE_REMOVE, 32'h0000_0005);
    // Extremes of the value range, a duplicate, then drain back to empty.
    send_request(MODE_INSERT, 32'h8000_0000);
    send_request(MODE_INSERT, 32'h7FFF_FFFF);
    send_request(MODE_INSERT, 32'h8000_0000);
    send_request(MODE_INSERT, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 32'h0000_0000);
    send_request(MODE_QUERY, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h8000_0000);
    send_request(MODE_REMOVE, 32'h8000_0000);
    send_request(MODE_REMOVE, 32'h7FFF_FFFF);
    send_request(MODE_REMOVE, 32'hFFFF_FFFF);
    send_request(MODE_REMOVE, 32'h0000_0000);
    // A tiny limit: full is reported even when the value is also a duplicate.
    write_limit(7'd2);
    send_request(MODE_INSERT, 32'h5555_5555);
    send_request(MODE_INSERT, 32'hAAAA_AAAA);
    send_request(MODE_INSERT, 32'h5555_5555);
    send_request(MODE_INSERT, 32'h0000_0001);
    send_request(MODE_REMOVE, 32'hAAAA_AAAA);
    send_request(MODE_INSERT, 32'hAAAA_AAAA);
    // Limit dropped below the held count: values stay, inserts are refused.
    write_limit(7'd0);
    send_request(MODE_INSERT, 32'h0000_0007);
    send_request(MODE_QUERY_ALT, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h5555_5555);
    send_request(MODE_REMOVE, 32'hAAAA_AAAA);
    send_request(MODE_INSERT, 32'h0000_0003);
  endtask

  // Result side: random back-pressure, with calm stretches chosen per phase.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        stall = pick_gap(sink_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                 idle_cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    plan_t p;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      p = phase_plan(ph);
      src_calm = (ph % 3 == 2);
      sink_calm = (ph % 4 == 1);
      write_limit(p.limit);
      for (int k = 0; k < p.items; k++) begin
        // Now and then the sender holds off until the block has emptied its pipeline.
        if ($urandom_range(0, 59) == 0) wait_drained();
        random_request(p);
      end
    end
    src_calm = 1'b0;
    sink_calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
    $display("Sent %0d requests and checked %0d results over %0d limit settings, peak size %0d.",
             sb.requests, sb.results, settings, sb.peak);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d full, %0d removed, %0d missed, %0d query.",
             sb.status_hits[ST_INSERTED], sb.status_hits[ST_DUPLICATE],
             sb.status_hits[ST_FULL], sb.status_hits[ST_REMOVED],
             sb.status_hits[ST_NOTFOUND], sb.status_hits[ST_QUERY]);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures in total.", sb.failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bsm_pkg.sv
sv/bsm_mem.sv
sv/bsm_scan.sv
sv/bounded_set_with_minimum.sv
sv/bsm_checker.sv
dv/bounded_set_with_minimum_tb.sv
